// ----- hw/rtl/prescaled_timer_with_compare_macros.svh -----
// Assertion macros shared by the timer modules.
`ifndef PRESCALED_TIMER_WITH_COMPARE_MACROS_SVH
`define PRESCALED_TIMER_WITH_COMPARE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ptc_pkg.sv -----
`default_nettype none

package ptc_pkg;

   localparam int COUNTER_WIDTH   = 16;
   localparam int PRESCALER_WIDTH = 8;
   localparam int CHANNEL_COUNT   = 4;
   localparam int DATA_WIDTH      = 16;
   localparam int STATUS_WIDTH    = 8;
   localparam int CMP_WIDTH       = (COUNTER_WIDTH > DATA_WIDTH) ? COUNTER_WIDTH : DATA_WIDTH;

   localparam int CTL_ENABLE_BIT = 0;
   localparam int CTL_OVF_IE_BIT = 1;
   localparam int CTL_CMP_EN_BIT = 2;
   localparam int CTL_CMP_IE_BIT = 3;
   localparam int ST_OVF_BIT     = 0;
   localparam int ST_CMP_BIT     = 1;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } opcode_type;

   typedef enum logic [3:0] {
      REG_CONTROL  = 4'd0,
      REG_RELOAD   = 4'd1,
      REG_COUNTER  = 4'd2,
      REG_CHANNEL0 = 4'd3,
      REG_STATUS   = 4'd7,
      REG_PRESCALE = 4'd8
   } reg_index_type;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [3:0]            reg_index;
      logic [DATA_WIDTH-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic                  irq;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ptc_core.sv -----
`default_nettype none
`include "prescaled_timer_with_compare_macros.svh"

module ptc_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             exec,
   input  wire ptc_pkg::req_type req,
   output ptc_pkg::rsp_type      rsp
);
   import ptc_pkg::*;

   localparam logic [PRESCALER_WIDTH-1:0] PRE_MAX = '1;
   localparam logic [COUNTER_WIDTH-1:0]   CNT_MAX = '1;

   logic [DATA_WIDTH-1:0]      ctl_ff, ctl_in;
   logic [COUNTER_WIDTH-1:0]   cnt_reload_ff, cnt_reload_in;
   logic [COUNTER_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0]      ch_ff [CHANNEL_COUNT];
   logic [DATA_WIDTH-1:0]      ch_in [CHANNEL_COUNT];
   logic [STATUS_WIDTH-1:0]    status_ff, status_in;
   logic [PRESCALER_WIDTH-1:0] pre_reload_ff, pre_reload_in;
   logic [PRESCALER_WIDTH-1:0] pre_ff, pre_in;
   logic [DATA_WIDTH-1:0]      read_mux;

   always_comb begin
      read_mux = '0;
      unique case (req.reg_index)
         REG_CONTROL:  read_mux = ctl_ff;
         REG_RELOAD:   read_mux = DATA_WIDTH'(cnt_reload_ff);
         REG_COUNTER:  read_mux = DATA_WIDTH'(cnt_ff);
         REG_STATUS:   read_mux = DATA_WIDTH'(status_ff);
         REG_PRESCALE: read_mux = DATA_WIDTH'(pre_reload_ff);
         default:      read_mux = '0;
      endcase
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         if (req.reg_index == 4'(REG_CHANNEL0 + i)) begin
            read_mux = ch_ff[i];
         end
      end
   end

   always_comb begin
      ctl_in        = ctl_ff;
      cnt_reload_in = cnt_reload_ff;
      cnt_in        = cnt_ff;
      ch_in         = ch_ff;
      status_in     = status_ff;
      pre_reload_in = pre_reload_ff;
      pre_in        = pre_ff;
      rsp.read_data = '0;
      if (exec) begin
         unique case (req.opcode)
            OP_TICK: begin
               if (ctl_ff[CTL_ENABLE_BIT]) begin
                  if (pre_ff == PRE_MAX) begin
                     pre_in = pre_reload_ff;
                     if (cnt_ff == CNT_MAX) begin
                        cnt_in                = cnt_reload_ff;
                        status_in[ST_OVF_BIT] = 1'b1;
                     end else begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                     if (ctl_ff[CTL_CMP_EN_BIT] &&
                         (CMP_WIDTH'(cnt_in) == CMP_WIDTH'(ch_ff[0]))) begin
                        status_in[ST_CMP_BIT] = 1'b1;
                     end
                  end else begin
                     pre_in = pre_ff + 1'b1;
                  end
               end
            end
            OP_READ: begin
               rsp.read_data = read_mux;
            end
            OP_WRITE: begin
               unique case (req.reg_index)
                  REG_CONTROL:  ctl_in        = req.write_data;
                  REG_RELOAD:   cnt_reload_in = COUNTER_WIDTH'(req.write_data);
                  REG_STATUS:   status_in     = status_ff & req.write_data[STATUS_WIDTH-1:0];
                  REG_PRESCALE: pre_reload_in = PRESCALER_WIDTH'(req.write_data);
                  default: ;
               endcase
               for (int i = 0; i < CHANNEL_COUNT; i++) begin
                  if (req.reg_index == 4'(REG_CHANNEL0 + i)) begin
                     ch_in[i] = req.write_data;
                  end
               end
            end
            default: ;
         endcase
      end
      rsp.irq = (status_in[ST_OVF_BIT] & ctl_in[CTL_OVF_IE_BIT]) |
                (status_in[ST_CMP_BIT] & ctl_in[CTL_CMP_IE_BIT]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff        <= '0;
         cnt_reload_ff <= '0;
         cnt_ff        <= '0;
         status_ff     <= '0;
         pre_reload_ff <= '0;
         pre_ff        <= '0;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            ch_ff[i] <= '0;
         end
      end else begin
         ctl_ff        <= ctl_in;
         cnt_reload_ff <= cnt_reload_in;
         cnt_ff        <= cnt_in;
         status_ff     <= status_in;
         pre_reload_ff <= pre_reload_in;
         pre_ff        <= pre_in;
         ch_ff         <= ch_in;
      end
   end

   `PTC_ASSERT_NEXT(a_counter_wrap_sets_overflow, clock, reset,
      exec && req.opcode == OP_TICK && ctl_ff[CTL_ENABLE_BIT] && pre_ff == PRE_MAX
      && cnt_ff == CNT_MAX, status_ff[ST_OVF_BIT], "Counter wrap did not set overflow.")
   `PTC_ASSERT_NOW(a_status_high_bits_clear, clock, reset, 1'b1,
      status_ff[STATUS_WIDTH-1:ST_CMP_BIT+1] == '0, "Unused status bits became set.")
   `PTC_ASSERT_NEXT(a_prescale_write_keeps_count, clock, reset,
      exec && req.opcode == OP_WRITE && req.reg_index == REG_PRESCALE,
      $stable(pre_ff), "Prescaler reload write disturbed the running prescaler.")

endmodule

`default_nettype wire

// ----- hw/rtl/prescaled_timer_with_compare.sv -----
// Prescaled up-counting timer with a compare channel and three storage channels.
// The request channel carries one request per cycle unless req_stall is high:
// a clock tick, a register read or a register write, selected by req_opcode.
// Every request, of any kind, yields exactly one response carrying the read
// data (zero unless a read) and the interrupt level after that request.
// A request is taken into an input register, executed against the timer
// registers once the output register is empty or its response is taken, and
// its response is held in the output register; one request per cycle is kept
// up while the response side does not stall. When it stalls, the output
// register holds its response and the input register still takes one more
// request; only then is req_stall raised, so no request is lost or repeated.
// Synchronous reset clears the valid flags of both pipeline registers and all
// timer registers, including the counter, prescaler and status flags.
`default_nettype none
`include "prescaled_timer_with_compare_macros.svh"

module prescaled_timer_with_compare (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [3:0]  req_reg_index,
   input  wire logic [15:0] req_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_read_data,
   output logic             rsp_irq
);
   import ptc_pkg::*;

   logic    s1_valid_ff;
   req_type s1_req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type exec_rsp;
   logic    advance;
   logic    accept;
   logic    exec;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign exec      = s1_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff.opcode     <= req_opcode;
         s1_req_ff.reg_index  <= req_reg_index;
         s1_req_ff.write_data <= req_write_data;
      end
   end

   ptc_core u_core (
      .clock (clock),
      .reset (reset),
      .exec  (exec),
      .req   (s1_req_ff),
      .rsp   (exec_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_ff <= exec_rsp;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_ff.read_data;
   assign rsp_irq       = rsp_ff.irq;

   `PTC_ASSERT_NEXT(a_held_request_kept, clock, reset, s1_valid_ff && !advance,
      s1_valid_ff && $stable(s1_req_ff), "Held request was lost or changed.")
   `PTC_ASSERT_NEXT(a_exec_gives_response, clock, reset, exec, rsp_valid_ff,
      "Executed request produced no response.")
   `PTC_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall,
      s1_valid_ff && rsp_valid_ff && rsp_stall, "Request stalled with room in the pipeline.")

endmodule

`default_nettype wire

// ----- test/prescaled_timer_with_compare_checker.sv -----
module prescaled_timer_with_compare_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [1:0]                     req_opcode,
   input  logic [3:0]                     req_reg_index,
   input  logic [ptc_pkg::DATA_WIDTH-1:0] req_write_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [ptc_pkg::DATA_WIDTH-1:0] rsp_read_data,
   input  logic                           rsp_irq,
   output int                             mismatches,
   output int                             outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import ptc_pkg::*;

   localparam int CHANNEL_BITS = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   logic [DATA_WIDTH-1:0]      control_reg;
   logic [COUNTER_WIDTH-1:0]   reload_reg;
   logic [COUNTER_WIDTH-1:0]   count_reg;
   logic [DATA_WIDTH-1:0]      channel_reg [CHANNEL_COUNT];
   logic [STATUS_WIDTH-1:0]    status_reg;
   logic [PRESCALER_WIDTH-1:0] prescale_reload_reg;
   logic [PRESCALER_WIDTH-1:0] prescale_count_reg;

   rsp_type due_responses [$];
   rsp_type oldest_due;
   int      error_count = 0;

   assign mismatches = error_count;

   task automatic report_mismatch(input string what, input logic [DATA_WIDTH-1:0] got,
                                  input logic [DATA_WIDTH-1:0] want);
      $display("%0t ns: response error on %s: got %h, wanted %h", $time, what, got, want);
      error_count++;
   endtask

   function automatic void clear_timer();
      control_reg         = '0;
      reload_reg          = '0;
      count_reg           = '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) channel_reg[i] = '0;
      status_reg          = '0;
      prescale_reload_reg = '0;
      prescale_count_reg  = '0;
   endfunction

   function automatic bit is_channel(input logic [3:0] idx);
      return (idx >= REG_CHANNEL0) && (idx < REG_CHANNEL0 + CHANNEL_COUNT);
   endfunction

   function automatic rsp_type advance_timer(input logic [1:0] op, input logic [3:0] idx,
                                             input logic [DATA_WIDTH-1:0] data);
      rsp_type r;
      r.read_data = '0;
      case (op)
         OP_TICK: begin
            if (control_reg[CTL_ENABLE_BIT]) begin
               if (prescale_count_reg == '1) begin
                  prescale_count_reg = prescale_reload_reg;
                  if (count_reg == '1) begin
                     count_reg = reload_reg;
                     status_reg[ST_OVF_BIT] = 1'b1;
                  end else begin
                     count_reg = count_reg + 1'b1;
                  end
                  if (control_reg[CTL_CMP_EN_BIT] &&
                      CMP_WIDTH'(count_reg) == CMP_WIDTH'(channel_reg[0]))
                     status_reg[ST_CMP_BIT] = 1'b1;
               end else begin
                  prescale_count_reg = prescale_count_reg + 1'b1;
               end
            end
         end
         OP_READ: begin
            if (is_channel(idx)) begin
               r.read_data = channel_reg[CHANNEL_BITS'(idx - REG_CHANNEL0)];
            end else begin
               case (idx)
                  REG_CONTROL:  r.read_data = control_reg;
                  REG_RELOAD:   r.read_data = DATA_WIDTH'(reload_reg);
                  REG_COUNTER:  r.read_data = DATA_WIDTH'(count_reg);
                  REG_STATUS:   r.read_data = DATA_WIDTH'(status_reg);
                  REG_PRESCALE: r.read_data = DATA_WIDTH'(prescale_reload_reg);
                  default:      r.read_data = '0;
               endcase
            end
         end
         OP_WRITE: begin
            if (is_channel(idx)) begin
               channel_reg[CHANNEL_BITS'(idx - REG_CHANNEL0)] = data;
            end else begin
               case (idx)
                  REG_CONTROL:  control_reg = data;
                  REG_RELOAD:   reload_reg = COUNTER_WIDTH'(data);
                  REG_STATUS:   status_reg = status_reg & data[STATUS_WIDTH-1:0];
                  REG_PRESCALE: prescale_reload_reg = data[PRESCALER_WIDTH-1:0];
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      r.irq = (status_reg[ST_OVF_BIT] & control_reg[CTL_OVF_IE_BIT]) |
              (status_reg[ST_CMP_BIT] & control_reg[CTL_CMP_IE_BIT]);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_timer();
         due_responses.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_responses.size() == 0) begin
               report_mismatch("unrequested response", rsp_read_data, '0);
            end else begin
               oldest_due = due_responses.pop_front();
               if (rsp_read_data !== oldest_due.read_data)
                  report_mismatch("read_data", rsp_read_data, oldest_due.read_data);
               if (rsp_irq !== oldest_due.irq)
                  report_mismatch("irq", DATA_WIDTH'(rsp_irq), DATA_WIDTH'(oldest_due.irq));
            end
         end
         if (req_valid && !req_stall)
            due_responses.push_back(advance_timer(req_opcode, req_reg_index, req_write_data));
         outstanding <= due_responses.size();
      end
   end

endmodule

// ----- test/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ptc_pkg::*;

   localparam logic [1:0] OP_UNUSED      = 2'd3;
   localparam logic [3:0] REG_UNMAPPED   = 4'd15;
   localparam int         WATCHDOG_LIMIT = 5000;
   localparam int         WARMUP_TICKS   = 66000;
   localparam int         PHASE_ITEMS    = 283;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode     = OP_TICK;
   logic [3:0]  req_reg_index  = REG_CONTROL;
   logic [15:0] req_write_data = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [15:0] rsp_read_data;
   logic        rsp_irq;

   int mismatches;
   int outstanding;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int quiet_cycles  = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   prescaled_timer_with_compare dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq        (rsp_irq)
   );

   prescaled_timer_with_compare_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq        (rsp_irq),
      .mismatches     (mismatches),
      .outstanding    (outstanding)
   );

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("prescaled_timer_with_compare: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [3:0] idx,
                               input logic [15:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_reg_index  <= idx;
      req_write_data <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic send_random_write();
      logic [15:0] data;
      logic [3:0]  idx;
      data = 16'($urandom);
      idx  = 4'($urandom_range(15));
      case ($urandom_range(11))
         0, 1: begin
            data[CTL_ENABLE_BIT] = ($urandom_range(9) != 0);
            send_request(OP_WRITE, REG_CONTROL, data);
         end
         2: begin
            if ($urandom_range(19) != 0) data[15:8] = 8'hFF;
            send_request(OP_WRITE, REG_RELOAD, data);
         end
         3: send_request(OP_WRITE, REG_COUNTER, data);
         4, 5: begin
            idx = REG_CHANNEL0 + 4'($urandom_range(CHANNEL_COUNT - 1));
            if ($urandom_range(3) != 0) data[15:8] = 8'hFF;
            send_request(OP_WRITE, idx, data);
         end
         6, 7: begin
            if ($urandom_range(1) == 0) data[7:0] = ~(8'h01 << $urandom_range(1));
            send_request(OP_WRITE, REG_STATUS, data);
         end
         8, 9: begin
            case ($urandom_range(3))
               0, 1: data[7:0] = 8'hFF;
               2: data[7:4] = 4'hF;
               default: ;
            endcase
            send_request(OP_WRITE, REG_PRESCALE, data);
         end
         10: send_request(OP_WRITE, 4'd9 + 4'($urandom_range(6)), data);
         default: send_request(OP_WRITE, idx, data);
      endcase
   endtask

   task automatic send_random_request();
      int          pick;
      logic [3:0]  idx;
      logic [15:0] data;
      pick = $urandom_range(99);
      idx  = 4'($urandom_range(15));
      data = 16'($urandom);
      if (pick < 58) send_request(OP_TICK, idx, data);
      else if (pick < 78) send_request(OP_READ, idx, data);
      else if (pick < 96) send_random_write();
      else send_request(OP_UNUSED, idx, data);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct <= 32;
      rsp_idle_pct  <= 84;
      send_request(OP_READ, REG_CONTROL, 16'h0000);
      send_request(OP_READ, REG_UNMAPPED, 16'hFFFF);
      send_request(OP_UNUSED, REG_CONTROL, 16'hFFFF);
      send_request(OP_WRITE, REG_COUNTER, 16'hFFFF);
      send_request(OP_READ, REG_COUNTER, 16'h0000);
      send_request(OP_WRITE, REG_CHANNEL0, 16'h0002);
      send_request(OP_WRITE, REG_CHANNEL0 + 4'd1, 16'hFFFF);
      send_request(OP_WRITE, REG_CHANNEL0 + 4'd2, 16'h0000);
      send_request(OP_WRITE, REG_CHANNEL0 + 4'd3, 16'hA5A5);
      send_request(OP_WRITE, REG_UNMAPPED, 16'hFFFF);
      send_request(OP_READ, REG_UNMAPPED, 16'h0000);
      send_request(OP_WRITE, REG_STATUS, 16'hFFFF);
      send_request(OP_READ, REG_STATUS, 16'h0000);
      send_request(OP_WRITE, REG_PRESCALE, 16'hFFFF);
      send_request(OP_WRITE, REG_RELOAD, 16'hFFFF);
      send_request(OP_TICK, REG_CONTROL, 16'h0000);
      send_request(OP_WRITE, REG_CONTROL, 16'h000F);
      repeat (4) send_request(OP_TICK, REG_CONTROL, 16'h0000);
      send_request(OP_READ, REG_PRESCALE, 16'h0000);
      send_request(OP_READ, REG_CHANNEL0 + 4'd3, 16'h0000);
      send_request(OP_READ, REG_RELOAD, 16'h0000);
      send_request(OP_WRITE, REG_CONTROL, 16'hFFFF);
      wait_for_drain();

      // The counter cannot be written, so run it through one full wrap to reach the reload range.
      send_idle_pct <= 0;
      rsp_idle_pct  <= 0;
      repeat (WARMUP_TICKS) send_request(OP_TICK, REG_CONTROL, 16'h0000);
      send_request(OP_READ, REG_STATUS, 16'h0000);
      send_request(OP_WRITE, REG_STATUS, 16'hFFFD);
      send_request(OP_WRITE, REG_RELOAD, 16'hFFC0);
      send_request(OP_WRITE, REG_CHANNEL0, 16'hFFE0);
      wait_for_drain();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct <= 32;
               rsp_idle_pct  <= 84;
            end
            1: begin
               send_idle_pct <= 84;
               rsp_idle_pct  <= 32;
            end
            default: begin
               send_idle_pct <= 0;
               rsp_idle_pct  <= 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_random_request();
            if (n == PHASE_ITEMS / 2) wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("prescaled_timer_with_compare: match");
      end else begin
         $display("prescaled_timer_with_compare: mismatch");
      end
      $finish;
   end

endmodule
